[src/mfd_pkg.sv]
// Shared types and codes for the multilevel feedback dispatcher.
`default_nettype none

package mfd_pkg;

  localparam int ID_W     = 4;
  localparam int ID_SPACE = 1 << ID_W;
  localparam int LEVELS   = 4;
  localparam int TIME_W   = 8;

  localparam logic [1:0] LVL_SYSTEM = 2'd0;
  localparam logic [1:0] LVL_LOWEST = 2'd3;

  localparam logic OP_ARRIVE = 1'b0;
  localparam logic OP_TICK   = 1'b1;

  localparam logic [2:0] EV_IDLE   = 3'd0;
  localparam logic [2:0] EV_SYSTEM = 3'd1;
  localparam logic [2:0] EV_START  = 3'd2;
  localparam logic [2:0] EV_RESUME = 3'd3;
  localparam logic [2:0] EV_ACCEPT = 3'd4;
  localparam logic [2:0] EV_REJECT = 3'd5;

  typedef struct packed {
    logic [2:0]        event_res;
    logic [ID_W-1:0]   job_out;
    logic [TIME_W-1:0] ran_ticks;
    logic              finished;
    logic [1:0]        new_level;
    logic [TIME_W-1:0] time_left;
  } res_t;

endpackage

`default_nettype wire

[src/multilevel_feedback_dispatcher_top.sv]
// Four-level feedback dispatcher: per-level job FIFOs, job tables and result stage.
//
// Input stream (s_*): one beat is either a job arrival (s_tuser = 0) carrying
// id, level and run time, or a scheduling tick (s_tuser = 1). Output stream
// (m_*): exactly one result beat per input beat, in order. The result kind
// (idle, system run, user start, user resume, accepted, rejected) is on m_tuser.
// A beat is registered at the input, resolved in one pass through the four-way
// priority pick, the FIFO heads and the job tables, and lands in the output
// register, which drives m_tvalid.
// Throughput is one beat per cycle while m_tready stays high; that rate is set by the single pass
// through the level pick and the register FIFOs, each item updating state
// before the next one reads it.
// When the receiver stalls, the result register holds and an empty input
// register can still take one more beat; s_tready then drops until m_tready returns.
// Reset (rst, synchronous) empties all queues, clears the active and started
// flags and drops both valid stages. Stored run times and levels are written
// on arrival and need no reset.
`default_nettype none

module multilevel_feedback_dispatcher_top #(
  parameter int MAX_JOBS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // job_id[3:0], level[5:4], run_time[13:6], zero pad
  input  wire logic        s_tuser,   // op
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // job_out[3:0], ran_ticks[11:4], finished[12],
                                      // new_level[14:13], time_left[22:15], zero pad
  output logic [2:0]       m_tuser    // event_res
);

  // only ids that fit the id field can ever be active
  localparam int NJ = (MAX_JOBS < mfd_pkg::ID_SPACE) ? MAX_JOBS : mfd_pkg::ID_SPACE;
  localparam int JW = $clog2(NJ);
  localparam int CW = $clog2(NJ + 1);
  localparam int TW = mfd_pkg::TIME_W;

  // input stage
  logic                  v1;
  logic                  op1;
  logic [mfd_pkg::ID_W-1:0] id1;
  logic [1:0]            lv1;
  logic [TW-1:0]         rt1;
  logic                  adv;

  // queues
  logic [JW-1:0] fifo_mem [mfd_pkg::LEVELS][NJ];
  logic [JW-1:0] rd_ptr   [mfd_pkg::LEVELS];
  logic [JW-1:0] wr_ptr   [mfd_pkg::LEVELS];
  logic [CW-1:0] cnt      [mfd_pkg::LEVELS];

  // job tables
  logic [TW-1:0] rem_tab [NJ];
  logic [1:0]    lvl_tab [NJ];
  logic [NJ-1:0] active;
  logic [NJ-1:0] started;

  // result stage
  mfd_pkg::res_t res;
  mfd_pkg::res_t res_next;

  // decode
  logic          in_range;
  logic [JW-1:0] idx;
  logic [TW-1:0] rt_fix;
  logic [1:0]    q_sel;
  logic          any_job;
  logic [JW-1:0] head_j;
  logic [TW-1:0] rem_dec;
  logic [1:0]    lvl_dem;

  logic          do_push;
  logic [1:0]    push_lv;
  logic [JW-1:0] push_id;
  logic          do_pop;
  logic          tab_we;
  logic [JW-1:0] tab_idx;
  logic [TW-1:0] rem_wd;
  logic          lvl_we;
  logic [1:0]    lvl_wd;
  logic          act_set;
  logic          act_clr;
  logic          st_set;
  logic          st_clr;

  assign adv      = v1 && (!m_tvalid || m_tready);
  assign s_tready = !v1 || adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s_tready) begin
      v1 <= s_tvalid;
    end
    if (s_tready && s_tvalid) begin
      op1 <= s_tuser;
      id1 <= s_tdata[3:0];
      lv1 <= s_tdata[5:4];
      rt1 <= s_tdata[13:6];
    end
  end

  assign in_range = 32'(id1) < MAX_JOBS;
  assign idx      = id1[JW-1:0];
  assign rt_fix   = (lv1 != mfd_pkg::LVL_SYSTEM && rt1 == '0) ? TW'(1) : rt1;

  // level 0 first, then 1, 2, 3
  always_comb begin
    any_job = 1'b1;
    if (cnt[0] != '0)      q_sel = 2'd0;
    else if (cnt[1] != '0) q_sel = 2'd1;
    else if (cnt[2] != '0) q_sel = 2'd2;
    else begin
      q_sel   = 2'd3;
      any_job = (cnt[3] != '0);
    end
  end

  assign head_j  = fifo_mem[q_sel][rd_ptr[q_sel]];
  assign rem_dec = (rem_tab[head_j] != '0) ? rem_tab[head_j] - TW'(1) : '0;
  assign lvl_dem = (lvl_tab[head_j] != mfd_pkg::LVL_LOWEST) ? lvl_tab[head_j] + 2'd1
                                                           : mfd_pkg::LVL_LOWEST;

  always_comb begin
    res_next = '0;
    do_push  = 1'b0;
    push_lv  = lv1;
    push_id  = idx;
    do_pop   = 1'b0;
    tab_we   = 1'b0;
    tab_idx  = idx;
    rem_wd   = rt_fix;
    lvl_we   = 1'b0;
    lvl_wd   = lv1;
    act_set  = 1'b0;
    act_clr  = 1'b0;
    st_set   = 1'b0;
    st_clr   = 1'b0;
    if (op1 == mfd_pkg::OP_ARRIVE) begin
      res_next.job_out = id1;
      if (!in_range || active[idx]) begin
        res_next.event_res = mfd_pkg::EV_REJECT;
      end else begin
        res_next.event_res = mfd_pkg::EV_ACCEPT;
        res_next.new_level = lv1;
        res_next.time_left = rt_fix;
        do_push = 1'b1;
        tab_we  = 1'b1;
        lvl_we  = 1'b1;
        act_set = 1'b1;
        st_clr  = 1'b1;
      end
    end else if (any_job) begin
      do_pop           = 1'b1;
      tab_idx          = head_j;
      tab_we           = 1'b1;
      res_next.job_out = mfd_pkg::ID_W'(head_j);
      if (q_sel == mfd_pkg::LVL_SYSTEM) begin
        res_next.event_res = mfd_pkg::EV_SYSTEM;
        res_next.ran_ticks = rem_tab[head_j];
        res_next.finished  = 1'b1;
        rem_wd  = '0;
        act_clr = 1'b1;
      end else begin
        res_next.event_res = started[head_j] ? mfd_pkg::EV_RESUME : mfd_pkg::EV_START;
        res_next.ran_ticks = TW'(1);
        st_set = 1'b1;
        rem_wd = rem_dec;
        if (rem_dec == '0) begin
          res_next.finished = 1'b1;
          act_clr = 1'b1;
        end else begin
          res_next.new_level = lvl_dem;
          res_next.time_left = rem_dec;
          lvl_we  = 1'b1;
          lvl_wd  = lvl_dem;
          do_push = 1'b1;
          push_lv = lvl_dem;
          push_id = head_j;
        end
      end
    end
  end

  // queue pointers; one push and one pop at most per beat
  for (genvar g = 0; g < mfd_pkg::LEVELS; g++) begin : g_lvl
    logic push_hit;
    logic pop_hit;
    assign push_hit = adv && do_push && (push_lv == 2'(g));
    assign pop_hit  = adv && do_pop && (q_sel == 2'(g));

    always_ff @(posedge clk) begin
      if (rst) begin
        rd_ptr[g] <= '0;
        wr_ptr[g] <= '0;
        cnt[g]    <= '0;
      end else begin
        if (push_hit) begin
          wr_ptr[g] <= (wr_ptr[g] == JW'(NJ - 1)) ? '0 : wr_ptr[g] + JW'(1);
        end
        if (pop_hit) begin
          rd_ptr[g] <= (rd_ptr[g] == JW'(NJ - 1)) ? '0 : rd_ptr[g] + JW'(1);
        end
        if (push_hit && !pop_hit) begin
          cnt[g] <= cnt[g] + CW'(1);
        end else if (pop_hit && !push_hit) begin
          cnt[g] <= cnt[g] - CW'(1);
        end
      end
      if (push_hit) begin
        fifo_mem[g][wr_ptr[g]] <= push_id;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && tab_we) begin
      rem_tab[tab_idx] <= rem_wd;
    end
    if (adv && lvl_we) begin
      lvl_tab[tab_idx] <= lvl_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active  <= '0;
      started <= '0;
    end else if (adv) begin
      if (act_set) active[tab_idx]  <= 1'b1;
      if (act_clr) active[tab_idx]  <= 1'b0;
      if (st_set)  started[tab_idx] <= 1'b1;
      if (st_clr)  started[tab_idx] <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (adv) begin
      res <= res_next;
    end
  end

  assign m_tuser = res.event_res;
  assign m_tdata = {1'b0, res.time_left, res.new_level, res.finished, res.ran_ticks,
                    res.job_out};

endmodule

`default_nettype wire

[src/mfd_checker.sv]
// Port-level checks for the dispatcher, bound to the top level.
`default_nettype none

module mfd_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [23:0] m_tdata,
  input wire logic [2:0]  m_tuser
);

  // output stage is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result beat right after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // a rejected arrival carries only the id
  a_reject_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == mfd_pkg::EV_REJECT |-> m_tdata[22:4] == '0)
    else $error("rejected beat with payload");

  // a system run always ends the job
  a_system_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == mfd_pkg::EV_SYSTEM
      |-> m_tdata[12] && m_tdata[14:13] == 2'd0 && m_tdata[22:15] == '0)
    else $error("system run not finished");

  // a user run always consumes one tick
  a_user_tick: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == mfd_pkg::EV_START || m_tuser == mfd_pkg::EV_RESUME)
      |-> m_tdata[11:4] == 8'd1)
    else $error("user run without one tick");

endmodule

bind multilevel_feedback_dispatcher_top mfd_checker u_mfd_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
